FILE: rtl/mrpt_pkg.sv
package mrpt_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Field widths
   localparam int ADDR_W = 64;
   localparam int PERM_W = 3;
   localparam int CMD_W  = 2;

   // Request command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

   // Permission masks
   localparam logic [PERM_W-1:0] PERM_READ = 3'b001;
   localparam logic [PERM_W-1:0] PERM_RW   = 3'b011;

   // One stored region
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] len;
      logic [PERM_W-1:0] perm;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic req_load;    // latch request fields, clear result
      logic cnt_clear;   // empty the table
      logic rd_last;     // read the last entry
      logic rd_first;    // read entry 0, restart scan
      logic rd_next;     // read the next entry, advance scan
      logic app_write;   // merge or add an entry
      logic q_capture;   // hold the selected entry
      logic q_finish;    // form the query result
      logic out_load;    // move result to the output register
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic cnt_zero;
      logic scan_stop;
      logic scan_last;
      logic out_free;
   } dp_status_type;

endpackage

FILE: rtl/mrpt_req_if.sv
interface mrpt_req_if;
   logic                          valid;
   logic                          ready;
   logic [mrpt_pkg::CMD_W-1:0]    command;
   logic [mrpt_pkg::ADDR_W-1:0]   addr;
   logic [mrpt_pkg::ADDR_W-1:0]   length;
   logic [mrpt_pkg::PERM_W-1:0]   perm;
   logic                          unmapped;
   logic                          need_write;

   modport source (output valid, command, addr, length, perm, unmapped, need_write,
                   input ready);
   modport sink   (input valid, command, addr, length, perm, unmapped, need_write,
                   output ready);
endinterface

FILE: rtl/mrpt_rsp_if.sv
interface mrpt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mrpt_pkg::ADDR_W-1:0]   accessible_bytes;
   logic                          found;
   logic                          status;

   modport source (output valid, accessible_bytes, found, status, input ready);
   modport sink   (input valid, accessible_bytes, found, status, output ready);
endinterface

FILE: rtl/memory_region_permission_table.sv
// Memory region permission table.
// req_bus carries one request: clear, append a region (start, length, perm,
// unmapped) or query an address with a read or write intent. rsp_bus returns
// exactly one response per request, in order: accessible_bytes and found for
// a query, status set when an append was dropped on a full table.
// Requests are processed one at a time; one table memory with a registered
// read and its own write port serves both appends and the query scan, which
// walks the entries from index 0 at one entry per cycle.
// A clear, no-op or unmapped append goes straight to the output step; an
// append reads the last entry, then merges or adds; a query scans to the
// first entry ending past the address and, if one exists, captures it.
// The next request is accepted in the cycle after the response is loaded.
// The response sits in an output register: a new request is accepted while
// it waits, and that request finishes as soon as the register is taken. A
// stalled receiver holds the block in its final step until rsp ready.
// Reset (synchronous) empties the table and drops any pending response; no
// clearing pass is needed, stored entries are only read below the fill count.
module memory_region_permission_table (
   input  logic        clock,
   input  logic        reset,
   mrpt_req_if.sink    req_bus,
   mrpt_rsp_if.source  rsp_bus
);

   mrpt_pkg::ctrl_cmd_type  cmd;
   mrpt_pkg::dp_status_type status;

   mrpt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_bus.valid),
      .req_command  (req_bus.command),
      .req_unmapped (req_bus.unmapped),
      .req_ready    (req_bus.ready),
      .status       (status),
      .cmd          (cmd)
   );

   mrpt_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .cmd     (cmd),
      .status  (status)
   );

endmodule

FILE: rtl/mrpt_ctrl.sv
module mrpt_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [mrpt_pkg::CMD_W-1:0]  req_command,
   input  logic                        req_unmapped,
   output logic                        req_ready,
   input  mrpt_pkg::dp_status_type     status,
   output mrpt_pkg::ctrl_cmd_type      cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_A_EVAL = 3'd1;
   localparam logic [2:0] S_Q_SCAN = 3'd2;
   localparam logic [2:0] S_Q_FIN  = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Sequence one request at a time
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_load = 1'b1;
               case (req_command)
                  mrpt_pkg::CMD_CLEAR: begin
                     cmd.cnt_clear = 1'b1;
                     state_in      = S_DONE;
                  end
                  mrpt_pkg::CMD_APPEND: begin
                     if (req_unmapped) begin
                        state_in = S_DONE;
                     end else begin
                        cmd.rd_last = 1'b1;
                        state_in    = S_A_EVAL;
                     end
                  end
                  mrpt_pkg::CMD_QUERY: begin
                     if (status.cnt_zero) begin
                        state_in = S_DONE;
                     end else begin
                        cmd.rd_first = 1'b1;
                        state_in     = S_Q_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_A_EVAL: begin
            cmd.app_write = 1'b1;
            state_in      = S_DONE;
         end
         S_Q_SCAN: begin
            if (status.scan_stop) begin
               cmd.q_capture = 1'b1;
               state_in      = S_Q_FIN;
            end else if (status.scan_last) begin
               state_in = S_DONE;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         S_Q_FIN: begin
            cmd.q_finish = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/mrpt_dp.sv
module mrpt_dp (
   input  logic                     clock,
   input  logic                     reset,
   mrpt_req_if.sink                 req_bus,
   mrpt_rsp_if.source               rsp_bus,
   input  mrpt_pkg::ctrl_cmd_type   cmd,
   output mrpt_pkg::dp_status_type  status
);

   localparam int AW = mrpt_pkg::ADDR_W;
   localparam int IW = mrpt_pkg::IDX_W;
   localparam int CW = mrpt_pkg::CNT_W;

   // Region storage
   mrpt_pkg::entry_type region_mem_ff [mrpt_pkg::TABLE_DEPTH];
   mrpt_pkg::entry_type rd_data_ff;
   mrpt_pkg::entry_type wr_entry;
   logic [IW-1:0]       rd_addr;
   logic [IW-1:0]       wr_addr;
   logic                wr_en;

   // Table fill and scan position
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic [IW-1:0] scan_idx_ff;
   logic [IW-1:0] scan_idx_in;
   logic [IW-1:0] last_idx;
   logic          cnt_full;

   // Latched request
   logic [AW-1:0]               addr_ff;
   logic [AW-1:0]               length_ff;
   logic [mrpt_pkg::PERM_W-1:0] perm_ff;
   logic                        need_write_ff;

   // Selected entry for a query
   logic [AW-1:0]               diff_ff;
   logic                        ge_ff;
   logic [AW-1:0]               hit_len_ff;
   logic [mrpt_pkg::PERM_W-1:0] hit_perm_ff;

   // Result and output registers
   logic [AW-1:0] res_bytes_ff;
   logic          res_found_ff;
   logic          res_status_ff;
   logic          rsp_valid_ff;
   logic [AW-1:0] rsp_bytes_ff;
   logic          rsp_found_ff;
   logic          rsp_status_ff;

   // Entry arithmetic
   logic [AW:0]                 entry_end;
   logic [AW:0]                 merge_sum;
   logic [AW-1:0]               merge_len;
   logic                        merge_ok;
   logic                        contained;
   logic [mrpt_pkg::PERM_W-1:0] need;

   assign last_idx  = IW'(cnt_ff - CW'(1));
   assign cnt_full  = (cnt_ff == CW'(mrpt_pkg::TABLE_DEPTH));
   assign entry_end = {1'b0, rd_data_ff.start} + {1'b0, rd_data_ff.len};
   assign merge_sum = {1'b0, rd_data_ff.len} + {1'b0, length_ff};
   assign merge_len = merge_sum[AW] ? {AW{1'b1}} : merge_sum[AW-1:0];
   assign merge_ok  = (cnt_ff != '0) && (rd_data_ff.perm == perm_ff)
                      && (entry_end == {1'b0, addr_ff});

   // Pick the read address
   always_comb begin
      scan_idx_in = scan_idx_ff;
      rd_addr     = scan_idx_ff;
      if (cmd.rd_last) begin
         rd_addr = last_idx;
      end else if (cmd.rd_first) begin
         rd_addr     = '0;
         scan_idx_in = '0;
      end else if (cmd.rd_next) begin
         rd_addr     = scan_idx_ff + IW'(1);
         scan_idx_in = scan_idx_ff + IW'(1);
      end
   end

   // Clear the table, or merge into the last entry or add a new one unless full
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = cnt_ff[IW-1:0];
      wr_entry = '{start: addr_ff, len: length_ff, perm: perm_ff};
      cnt_in   = cnt_ff;
      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.app_write) begin
         if (merge_ok) begin
            wr_en    = 1'b1;
            wr_addr  = last_idx;
            wr_entry = '{start: rd_data_ff.start, len: merge_len, perm: rd_data_ff.perm};
         end else if (!cnt_full) begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         region_mem_ff[wr_addr] <= wr_entry;
      end
      rd_data_ff <= region_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
   end

   // Hold the request fields
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         addr_ff       <= req_bus.addr;
         length_ff     <= req_bus.length;
         perm_ff       <= req_bus.perm;
         need_write_ff <= req_bus.need_write;
      end
   end

   // Capture offset into the first entry ending past the address
   always_ff @(posedge clock) begin
      if (cmd.q_capture) begin
         diff_ff     <= addr_ff - rd_data_ff.start;
         ge_ff       <= (addr_ff >= rd_data_ff.start);
         hit_len_ff  <= rd_data_ff.len;
         hit_perm_ff <= rd_data_ff.perm;
      end
   end

   assign contained = ge_ff && (diff_ff < hit_len_ff);
   assign need      = need_write_ff ? mrpt_pkg::PERM_RW : mrpt_pkg::PERM_READ;

   // Form the result
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         res_bytes_ff  <= '0;
         res_found_ff  <= 1'b0;
         res_status_ff <= 1'b0;
      end else if (cmd.app_write) begin
         res_status_ff <= !merge_ok && cnt_full;
      end else if (cmd.q_finish) begin
         res_found_ff <= contained;
         res_bytes_ff <= (contained && ((hit_perm_ff & need) == need))
                         ? (hit_len_ff - diff_ff) : '0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_bytes_ff  <= res_bytes_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.accessible_bytes = rsp_bytes_ff;
   assign rsp_bus.found            = rsp_found_ff;
   assign rsp_bus.status           = rsp_status_ff;

   assign status.cnt_zero  = (cnt_ff == '0);
   assign status.scan_stop = (entry_end > {1'b0, addr_ff});
   assign status.scan_last = ((CW'(scan_idx_ff) + CW'(1)) == cnt_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_bus.ready;

   // Fill never passes the table depth
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(mrpt_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // A result is never loaded over one still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("result overwritten while stalled");

   // Clear empties the table
   assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_clear |=> (cnt_ff == '0))
      else $error("clear left entries");

   // A dropped append leaves the fill alone and flags it
   assert property (@(posedge clock) disable iff (reset)
      (cmd.app_write && cnt_full && !merge_ok) |=> ((cnt_ff == $past(cnt_ff)) && res_status_ff))
      else $error("full-table append not dropped");

endmodule

FILE: tb/tb_memory_region_permission_table.sv
module tb_memory_region_permission_table;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [mrpt_pkg::CMD_W-1:0]  command;
      logic [mrpt_pkg::ADDR_W-1:0] addr;
      logic [mrpt_pkg::ADDR_W-1:0] length;
      logic [mrpt_pkg::PERM_W-1:0] perm;
      logic                        unmapped;
      logic                        need_write;
   } region_request_type;

   typedef struct {
      logic [mrpt_pkg::ADDR_W-1:0] bytes;
      logic                        found;
      logic                        status;
   } access_answer_type;

   // Shadow copy of the region table and the answers still owed by the block
   class permission_scoreboard;
      logic [mrpt_pkg::ADDR_W-1:0] starts  [mrpt_pkg::TABLE_DEPTH];
      logic [mrpt_pkg::ADDR_W-1:0] lengths [mrpt_pkg::TABLE_DEPTH];
      logic [mrpt_pkg::PERM_W-1:0] perms   [mrpt_pkg::TABLE_DEPTH];
      int unsigned                 fill;
      access_answer_type           pending_answers [$];
      int unsigned                 mismatches;
      int unsigned                 n_appends, n_drops, n_queries, n_hits, n_clears;

      // Apply one accepted request to the shadow table and queue its answer
      function void note_request(region_request_type r);
         access_answer_type           ans;
         logic [mrpt_pkg::ADDR_W:0]   span_end;
         logic [mrpt_pkg::ADDR_W:0]   grown;
         logic [mrpt_pkg::ADDR_W-1:0] offset;
         logic [mrpt_pkg::PERM_W-1:0] need;
         int unsigned                 last;
         int unsigned                 idx;
         bit                          merged;
         ans = '{bytes: '0, found: 1'b0, status: 1'b0};
         merged = 1'b0;
         case (r.command)
            mrpt_pkg::CMD_CLEAR: begin
               fill = 0;
               n_clears++;
            end
            mrpt_pkg::CMD_APPEND: begin
               if (!r.unmapped) begin
                  n_appends++;
                  // grow the last entry when the new region abuts it with equal perm
                  if (fill > 0) begin
                     last = fill - 1;
                     span_end = {1'b0, starts[last]} + {1'b0, lengths[last]};
                     if (perms[last] == r.perm && !span_end[mrpt_pkg::ADDR_W] &&
                         span_end[mrpt_pkg::ADDR_W-1:0] == r.addr) begin
                        grown = {1'b0, lengths[last]} + {1'b0, r.length};
                        lengths[last] = grown[mrpt_pkg::ADDR_W] ? {mrpt_pkg::ADDR_W{1'b1}}
                                                                : grown[mrpt_pkg::ADDR_W-1:0];
                        merged = 1'b1;
                     end
                  end
                  if (!merged) begin
                     if (fill >= mrpt_pkg::TABLE_DEPTH) begin
                        ans.status = 1'b1;
                        n_drops++;
                     end else begin
                        starts[fill]  = r.addr;
                        lengths[fill] = r.length;
                        perms[fill]   = r.perm;
                        fill++;
                     end
                  end
               end
            end
            mrpt_pkg::CMD_QUERY: begin
               n_queries++;
               // first entry whose 65-bit end lies past the address
               idx = 0;
               while (idx < fill) begin
                  span_end = {1'b0, starts[idx]} + {1'b0, lengths[idx]};
                  if (span_end[mrpt_pkg::ADDR_W] || span_end[mrpt_pkg::ADDR_W-1:0] > r.addr)
                     break;
                  idx++;
               end
               if (idx < fill) begin
                  offset = r.addr - starts[idx];
                  if (r.addr >= starts[idx] && offset < lengths[idx]) begin
                     ans.found = 1'b1;
                     n_hits++;
                     need = r.need_write ? mrpt_pkg::PERM_RW : mrpt_pkg::PERM_READ;
                     if ((perms[idx] & need) == need)
                        ans.bytes = lengths[idx] - offset;
                  end
               end
            end
            default: ;
         endcase
         pending_answers = {pending_answers, ans};
      endfunction

      // Compare one accepted response with the oldest owed answer
      function void check_response(logic [mrpt_pkg::ADDR_W-1:0] bytes, logic found,
                                   logic status);
         access_answer_type want;
         if (pending_answers.size() == 0) begin
            $display("%0t: response with none owed, bytes %h found %b status %b",
                     $time, bytes, found, status);
            mismatches++;
            return;
         end
         want = pending_answers.pop_front();
         if (bytes !== want.bytes) begin
            $display("%0t: accessible_bytes expected %h, actual %h",
                     $time, want.bytes, bytes);
            mismatches++;
         end
         if (found !== want.found) begin
            $display("%0t: found expected %b, actual %b", $time, want.found, found);
            mismatches++;
         end
         if (status !== want.status) begin
            $display("%0t: status expected %b, actual %b", $time, want.status, status);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   mrpt_req_if req_if ();
   mrpt_rsp_if rsp_if ();

   memory_region_permission_table dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   permission_scoreboard book = new();

   int unsigned work_items = 0;
   int unsigned burst_left = 0;
   int unsigned rx_mode    = 0;
   int unsigned rx_stall   = 0;
   int unsigned rx_count   = 0;

   always #5 clock = ~clock;

   // Predict on every accepted request, check every accepted response
   always @(posedge clock) begin
      region_request_type seen;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            seen.command    = req_if.command;
            seen.addr       = req_if.addr;
            seen.length     = req_if.length;
            seen.perm       = req_if.perm;
            seen.unmapped   = req_if.unmapped;
            seen.need_write = req_if.need_write;
            book.note_request(seen);
         end
         if (rsp_if.valid && rsp_if.ready)
            book.check_response(rsp_if.accessible_bytes, rsp_if.found, rsp_if.status);
      end
   end

   // Receiver: switch at random among four stall patterns
   always @(posedge clock) begin
      if (rx_count == 0) begin
         rx_mode  = $urandom_range(0, 3);
         rx_count = $urandom_range(50, 400);
      end
      rx_count--;
      case (rx_mode)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= 1'($urandom_range(0, 1));
         2: rsp_if.ready <= ($urandom_range(0, 7) != 0);
         default: begin
            if (rx_stall != 0) begin
               rx_stall--;
               rsp_if.ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
               rx_stall = $urandom_range(2, 11);
               rsp_if.ready <= 1'b0;
            end else begin
               rsp_if.ready <= 1'b1;
            end
         end
      endcase
   end

   function automatic logic [mrpt_pkg::ADDR_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic region_request_type make_request(logic [mrpt_pkg::CMD_W-1:0] cmd,
                                                       logic [mrpt_pkg::ADDR_W-1:0] a,
                                                       logic [mrpt_pkg::ADDR_W-1:0] len,
                                                       logic [mrpt_pkg::PERM_W-1:0] p,
                                                       logic um, logic ww);
      region_request_type r;
      r.command    = cmd;
      r.addr       = a;
      r.length     = len;
      r.perm       = p;
      r.unmapped   = um;
      r.need_write = ww;
      return r;
   endfunction

   // Present one request and hold it until the block takes it
   task automatic send_request(region_request_type r);
      req_if.valid      <= 1'b1;
      req_if.command    <= r.command;
      req_if.addr       <= r.addr;
      req_if.length     <= r.length;
      req_if.perm       <= r.perm;
      req_if.unmapped   <= r.unmapped;
      req_if.need_write <= r.need_write;
      @(posedge clock);
      while (req_if.ready !== 1'b1)
         @(posedge clock);
   endtask

   task automatic pause_sender(int unsigned cycles);
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Send in bursts of random length with random gaps between them
   task automatic issue(region_request_type r);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0)
            pause_sender(gap);
         burst_left = $urandom_range(1, 20);
      end
      send_request(r);
      burst_left--;
      if (!(r.command == mrpt_pkg::CMD_NOP ||
            (r.command == mrpt_pkg::CMD_APPEND && r.unmapped)))
         work_items++;
   endtask

   // Hold the sender until every owed response has come back
   task automatic wait_for_answers();
      req_if.valid <= 1'b0;
      do
         @(posedge clock);
      while (book.pending_answers.size() != 0);
   endtask

   // Load an ascending run of regions, then probe around their edges
   task automatic table_session(int unsigned n_regions, bit start_clean, bit fill_table);
      logic [mrpt_pkg::ADDR_W-1:0] cursor, rstart, rlen, probe;
      logic [mrpt_pkg::ADDR_W-1:0] known_start [$];
      logic [mrpt_pkg::ADDR_W-1:0] known_len [$];
      logic [mrpt_pkg::PERM_W-1:0] p, last_perm;
      logic                        um;
      int unsigned                 k, pick, n_probes;
      if (start_clean)
         issue(make_request(mrpt_pkg::CMD_CLEAR, rand64(), rand64(), 3'($urandom),
                            1'($urandom), 1'($urandom)));
      case (fill_table ? 3 : $urandom_range(0, 3))
         0:       cursor = 64'($urandom_range(0, 65535));
         1:       cursor = rand64();
         2:       cursor = 64'hFFFF_FFFF_FFFF_0000 | 64'($urandom_range(0, 65535));
         default: cursor = {$urandom, 32'h0};
      endcase
      last_perm = 3'($urandom);
      for (k = 0; k < n_regions; k++) begin
         p = 3'($urandom);
         rstart = cursor;
         if (fill_table) begin
            // keep a gap so every append takes a fresh entry
            rstart = cursor + 64'($urandom_range(1, 4096));
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: p = last_perm;
               4, 5, 6:    rstart = cursor + 64'($urandom_range(1, 256));
               7:          rstart = cursor + 64'($urandom) + 64'd1;
               8:          ;
               default:    rstart = rand64();
            endcase
         end
         case (fill_table ? 3 : $urandom_range(0, 15))
            0:       rlen = '0;
            1:       rlen = rand64();
            2:       rlen = 64'd1;
            default: rlen = 64'($urandom_range(1, 4096));
         endcase
         um = !fill_table && ($urandom_range(0, 9) == 0);
         issue(make_request(mrpt_pkg::CMD_APPEND, rstart, rlen, p, um, 1'($urandom)));
         if (!um) begin
            known_start = {known_start, rstart};
            known_len   = {known_len, rlen};
            cursor = rstart + rlen;
            last_perm = p;
         end
         // sprinkle stray requests into the load
         if (!fill_table && $urandom_range(0, 11) == 0)
            issue(make_request(2'($urandom_range(1, 3)), rand64(), rand64(), 3'($urandom),
                               1'($urandom), 1'($urandom)));
      end
      if (fill_table) begin
         // full table: an abutting append still merges, a new region drops
         issue(make_request(mrpt_pkg::CMD_APPEND, cursor, 64'($urandom_range(1, 64)),
                            last_perm, 1'b0, 1'b0));
         repeat ($urandom_range(1, 3))
            issue(make_request(mrpt_pkg::CMD_APPEND, rand64(), rand64(), 3'($urandom),
                               1'b0, 1'($urandom)));
      end
      n_probes = fill_table ? $urandom_range(10, 40) : $urandom_range(2, 2 * n_regions + 2);
      for (k = 0; k < n_probes; k++) begin
         if (known_start.size() != 0 && $urandom_range(0, 7) != 0) begin
            pick   = $urandom_range(0, known_start.size() - 1);
            rstart = known_start[pick];
            rlen   = known_len[pick];
            case ($urandom_range(0, 5))
               0:       probe = rstart;
               1:       probe = rstart + rlen - 1;
               2:       probe = rstart + rlen;
               3:       probe = rstart - 1;
               default: probe = (rlen == 0) ? rstart : rstart + rand64() % rlen;
            endcase
         end else begin
            probe = rand64();
         end
         issue(make_request(mrpt_pkg::CMD_QUERY, probe, rand64(), 3'($urandom),
                            1'($urandom), 1'($urandom)));
      end
   endtask

   initial begin
      int unsigned target, choice;
      req_if.valid      <= 1'b0;
      req_if.command    <= mrpt_pkg::CMD_NOP;
      req_if.addr       <= '0;
      req_if.length     <= '0;
      req_if.perm       <= '0;
      req_if.unmapped   <= 1'b0;
      req_if.need_write <= 1'b0;
      reset             <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, merges, top of address space, saturation
      issue(make_request(mrpt_pkg::CMD_QUERY, 64'h1000, '0, mrpt_pkg::PERM_RW, 1'b0, 1'b0));
      issue(make_request(mrpt_pkg::CMD_NOP, '1, '1, 3'b111, 1'b1, 1'b1));
      issue(make_request(mrpt_pkg::CMD_APPEND, 64'h1000, 64'h100, mrpt_pkg::PERM_RW,
                         1'b0, 1'b0));
      issue(make_request(mrpt_pkg::CMD_APPEND, 64'h1100, 64'h80, mrpt_pkg::PERM_RW,
                         1'b0, 1'b0));
      issue(make_request(mrpt_pkg::CMD_APPEND, 64'h1180, 64'h40, mrpt_pkg::PERM_READ,
                         1'b0, 1'b0));
      issue(make_request(mrpt_pkg::CMD_APPEND, 64'h2000, 64'h10, mrpt_pkg::PERM_RW,
                         1'b1, 1'b0));
      issue(make_request(mrpt_pkg::CMD_APPEND, 64'h3000, 64'h0, 3'b111, 1'b0, 1'b0));
      issue(make_request(mrpt_pkg::CMD_APPEND, 64'hFFFF_FFFF_FFFF_FF00, 64'h200,
                         mrpt_pkg::PERM_RW, 1'b0, 1'b0));
      issue(make_request(mrpt_pkg::CMD_APPEND, 64'h100, 64'h10, mrpt_pkg::PERM_RW,
                         1'b0, 1'b0));
      issue(make_request(mrpt_pkg::CMD_QUERY, 64'h1000, '0, '0, 1'b0, 1'b1));
      issue(make_request(mrpt_pkg::CMD_QUERY, 64'h117F, '0, '0, 1'b0, 1'b0));
      issue(make_request(mrpt_pkg::CMD_QUERY, 64'h1180, '0, '0, 1'b0, 1'b1));
      issue(make_request(mrpt_pkg::CMD_QUERY, 64'h0FFF, '0, '0, 1'b0, 1'b0));
      issue(make_request(mrpt_pkg::CMD_QUERY, 64'h11C0, '0, '0, 1'b0, 1'b0));
      issue(make_request(mrpt_pkg::CMD_QUERY, 64'h3000, '0, '0, 1'b0, 1'b0));
      issue(make_request(mrpt_pkg::CMD_QUERY, '1, '0, '0, 1'b0, 1'b1));
      issue(make_request(mrpt_pkg::CMD_QUERY, 64'h108, '0, '0, 1'b0, 1'b0));
      issue(make_request(mrpt_pkg::CMD_CLEAR, '0, '0, '0, 1'b0, 1'b0));
      issue(make_request(mrpt_pkg::CMD_APPEND, '0, '1, 3'b111, 1'b0, 1'b0));
      issue(make_request(mrpt_pkg::CMD_APPEND, '1, '1, 3'b111, 1'b0, 1'b0));
      issue(make_request(mrpt_pkg::CMD_QUERY, '0, '0, '0, 1'b0, 1'b1));
      issue(make_request(mrpt_pkg::CMD_QUERY, '1, '0, '0, 1'b0, 1'b0));
      issue(make_request(mrpt_pkg::CMD_CLEAR, '1, '1, 3'b111, 1'b1, 1'b1));
      wait_for_answers();

      // Random: mostly well-formed table loads with probes, some full tables and noise
      target = work_items + 1100;
      while (work_items < target) begin
         choice = $urandom_range(0, 19);
         if (choice == 0)
            table_session(mrpt_pkg::TABLE_DEPTH, 1'b1, 1'b1);
         else if (choice == 1)
            repeat (8)
               issue(make_request(2'($urandom), rand64(), rand64(), 3'($urandom),
                                  1'($urandom), 1'($urandom)));
         else
            table_session($urandom_range(1, 12), $urandom_range(0, 4) != 0, 1'b0);
         if ($urandom_range(0, 9) == 0)
            wait_for_answers();
      end

      // Drain, then watch for stray responses
      wait_for_answers();
      repeat (80) @(posedge clock);

      $display("Covered %0d appends (%0d dropped on a full table), %0d queries",
               book.n_appends, book.n_drops, book.n_queries);
      $display("(%0d inside a region) and %0d clears under random stalls.",
               book.n_hits, book.n_clears);
      if (book.mismatches == 0 && book.pending_answers.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Watchdog
   initial begin
      #(10_000_000);
      $display("Timeout waiting for the block");
      $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: memory_region_permission_table.f
rtl/mrpt_pkg.sv
rtl/mrpt_req_if.sv
rtl/mrpt_rsp_if.sv
rtl/mrpt_ctrl.sv
rtl/mrpt_dp.sv
rtl/memory_region_permission_table.sv
tb/tb_memory_region_permission_table.sv
